/* rtl/mah_pkg.sv */
`timescale 1ns / 1ps
package mah_pkg;

  localparam int CordicSteps = 16;
  localparam int CntW        = 5;

  localparam logic [1:0] StatusValid = 2'd0;
  localparam logic [1:0] StatusRetry = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic [1:0] RegAutoRange   = 2'd0;
  localparam logic [1:0] RegInitialGain = 2'd1;

  localparam logic [2:0] TopGain   = 3'd6;
  localparam int         SatLimit  = 2040;
  localparam int         HalfTurn  = 180 * 65536;
  localparam int         LimFull   = 11520;
  localparam int         LimHalf   = 5760;

  // Counts per gauss of the x and y axes for each gain step.
  function automatic logic [10:0] lsb_xy(input logic [2:0] g);
    logic [10:0] r;
    unique case (g)
      3'd0:    r = 11'd1100;
      3'd1:    r = 11'd855;
      3'd2:    r = 11'd670;
      3'd3:    r = 11'd450;
      3'd4:    r = 11'd400;
      3'd5:    r = 11'd330;
      default: r = 11'd230;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] lsb_z(input logic [2:0] g);
    logic [10:0] r;
    unique case (g)
      3'd0:    r = 11'd980;
      3'd1:    r = 11'd760;
      3'd2:    r = 11'd600;
      3'd3:    r = 11'd400;
      3'd4:    r = 11'd355;
      3'd5:    r = 11'd295;
      default: r = 11'd205;
    endcase
    return r;
  endfunction

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic [21:0] atan_tab(input logic [CntW-1:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/magnetometer_autorange_heading.sv */
`timescale 1ns / 1ps
// A sample without data ready, or one that raises the gain, goes from the check state straight
// to the output state; a full reading passes the check, three divisions, the two squares, the
// root, three CORDIC runs (each of CordicSteps iterations) and then the output state.
// One item at a time: a new item is accepted in the idle state once the result is offered,
// and the block waits in the output state while an earlier result is still stalled.
// Reset clears the gain step, the auto-range enable and all handshake state.
module magnetometer_autorange_heading (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // raw_x[11:0], raw_y[23:12], raw_z[35:24], zero pad
  input  logic        s_axis_tuser_i,  // data_ready
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // mag_x[14:0], mag_y[29:15], mag_z[44:30], heading[59:45], roll[74:60],
  // pitch[88:75], gain_step[91:89], zero pad
  output logic [95:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);
  import mah_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHK   = 11'b00000000010,
    S_DLOAD = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_SQ0   = 11'b00000010000,
    S_SQ1   = 11'b00000100000,
    S_SQRT  = 11'b00001000000,
    S_CINIT = 11'b00010000000,
    S_CORD  = 11'b00100000000,
    S_CFIN  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic               auto_q;
  logic [2:0]         gain_q;
  logic signed [11:0] rx_q, ry_q, rz_q;
  logic               dr_q;
  logic [1:0]         status_q;
  logic [1:0]         ax_q;
  logic [CntW-1:0]    cnt_q;
  logic [22:0]        num_q;
  logic [11:0]        rem_q;
  logic               neg_q;
  logic signed [14:0] mx_q, my_q, mz_q;
  logic [28:0]        sq_q;
  logic [49:0]        rad_q;
  logic [24:0]        root_q;
  logic [26:0]        srem_q;
  logic signed [27:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic               zz_q;
  logic signed [14:0] hd_q, rl_q;
  logic signed [13:0] pt_q;
  logic               m_valid_q;
  logic [95:0]        m_data_q;
  logic [1:0]         m_user_q;

  // Operand selection for the divider.
  logic signed [11:0] raw_sel;
  logic [11:0]        raw_abs;
  logic [10:0]        lsb_sel;
  logic [11:0]        dvs;
  logic [12:0]        rem_sh;
  logic               div_ge;
  logic [22:0]        num_next;
  logic [14:0]        quo;
  logic signed [14:0] quo_s;

  // Shared multiplier for the sum of squares.
  logic signed [14:0] mul_a;
  logic signed [29:0] mul_p;

  // Root recurrence.
  logic [26:0]        srem_sh, trial;
  logic               sq_ge;

  // CORDIC.
  logic signed [27:0] opx, opy, cx_sh, cy_sh;
  logic signed [25:0] tab_s;
  logic [25:0]        zabs;
  logic [15:0]        zrnd, zlim, zclamp;
  logic [15:0]        zres;
  logic               sat;
  logic               out_free;

  always_comb begin
    unique case (ax_q)
      2'd0:    raw_sel = rx_q;
      2'd1:    raw_sel = ry_q;
      default: raw_sel = rz_q;
    endcase
  end

  assign raw_abs  = raw_sel[11] ? (~raw_sel + 12'd1) : raw_sel;
  assign lsb_sel  = (ax_q == 2'd2) ? lsb_z(gain_q) : lsb_xy(gain_q);
  assign dvs      = {lsb_sel, 1'b0};
  assign rem_sh   = {rem_q, num_q[22]};
  assign div_ge   = rem_sh >= {1'b0, dvs};
  assign num_next = {num_q[21:0], div_ge};
  assign quo      = num_next[14:0];
  assign quo_s    = neg_q ? -$signed(quo) : $signed(quo);

  assign mul_a = (state_q == S_SQ0) ? my_q : mz_q;
  assign mul_p = mul_a * mul_a;

  assign srem_sh = {srem_q[24:0], rad_q[49:48]};
  assign trial   = {root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial;

  always_comb begin
    unique case (ax_q)
      2'd0: begin
        opy = 28'(my_q) <<< 10;
        opx = 28'(mx_q) <<< 10;
      end
      2'd1: begin
        opy = -(28'(my_q) <<< 10);
        opx = 28'(mz_q) <<< 10;
      end
      default: begin
        opy = 28'(mx_q) <<< 10;
        opx = $signed({3'b000, root_q});
      end
    endcase
  end

  assign cx_sh = cx_q >>> cnt_q;
  assign cy_sh = cy_q >>> cnt_q;
  assign tab_s = $signed({4'b0000, atan_tab(cnt_q)});

  assign zabs   = cz_q[25] ? 26'(-cz_q) : 26'(cz_q);
  assign zrnd   = 16'((zabs + 26'd512) >> 10);
  assign zlim   = (ax_q == 2'd2) ? 16'(LimHalf) : 16'(LimFull);
  assign zclamp = (zrnd > zlim) ? zlim : zrnd;
  assign zres   = zz_q ? 16'd0 : (cz_q[25] ? -zclamp : zclamp);

  assign sat = (rx_q >= 12'sd2040) | (rx_q <= -12'sd2040) |
               (ry_q >= 12'sd2040) | (ry_q <= -12'sd2040) |
               (rz_q >= 12'sd2040) | (rz_q <= -12'sd2040);

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_CHK;
      S_CHK: begin
        if (!dr_q || (auto_q && sat && gain_q < TopGain)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == CntW'(22)) begin
          state_d = (ax_q == 2'd2) ? S_SQ0 : S_DLOAD;
        end
      end
      S_SQ0:   state_d = S_SQ1;
      S_SQ1:   state_d = S_SQRT;
      S_SQRT:  if (cnt_q == CntW'(24)) state_d = S_CINIT;
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (cnt_q == CntW'(CordicSteps - 1)) state_d = S_CFIN;
      S_CFIN:  state_d = (ax_q == 2'd2) ? S_DONE : S_CINIT;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      auto_q    <= 1'b0;
      gain_q    <= 3'd0;
      m_valid_q <= 1'b0;
      ax_q      <= 2'd0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == RegAutoRange) begin
          auto_q <= cfg_data_i[0];
        end else if (cfg_index_i == RegInitialGain) begin
          gain_q <= (cfg_data_i > TopGain) ? TopGain : cfg_data_i;
        end
      end
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          ax_q  <= 2'd0;
          cnt_q <= '0;
        end
        S_CHK: begin
          if (dr_q && auto_q && sat && gain_q < TopGain) gain_q <= gain_q + 3'd1;
        end
        S_DIV: begin
          if (cnt_q == CntW'(22)) begin
            cnt_q <= '0;
            ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_SQRT: cnt_q <= (cnt_q == CntW'(24)) ? '0 : cnt_q + CntW'(1);
        S_CORD: cnt_q <= (cnt_q == CntW'(CordicSteps - 1)) ? '0 : cnt_q + CntW'(1);
        S_CFIN: ax_q <= ax_q + 2'd1;
        S_DONE: begin
          if (out_free) m_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          rx_q <= $signed(s_axis_tdata_i[11:0]);
          ry_q <= $signed(s_axis_tdata_i[23:12]);
          rz_q <= $signed(s_axis_tdata_i[35:24]);
          dr_q <= s_axis_tuser_i;
        end
      end
      S_CHK: begin
        if (!dr_q) begin
          status_q <= StatusEmpty;
        end else if (auto_q && sat && gain_q < TopGain) begin
          status_q <= StatusRetry;
        end else begin
          status_q <= StatusValid;
        end
      end
      S_DLOAD: begin
        num_q <= 23'(raw_abs) * 23'd3200 + 23'(lsb_sel);
        rem_q <= '0;
        neg_q <= raw_sel[11];
      end
      S_DIV: begin
        num_q <= num_next;
        rem_q <= div_ge ? 12'(rem_sh - {1'b0, dvs}) : rem_sh[11:0];
        if (cnt_q == CntW'(22)) begin
          unique case (ax_q)
            2'd0:    mx_q <= quo_s;
            2'd1:    my_q <= quo_s;
            default: mz_q <= quo_s;
          endcase
        end
      end
      S_SQ0: sq_q <= mul_p[28:0];
      S_SQ1: begin
        rad_q  <= {1'b0, sq_q + mul_p[28:0], 20'd0};
        root_q <= '0;
        srem_q <= '0;
      end
      S_SQRT: begin
        rad_q  <= {rad_q[47:0], 2'b00};
        srem_q <= sq_ge ? srem_sh - trial : srem_sh;
        root_q <= {root_q[23:0], sq_ge};
      end
      S_CINIT: begin
        zz_q <= (opx == 28'sd0) && (opy == 28'sd0);
        if (opx < 0) begin
          cx_q <= -opx;
          cy_q <= -opy;
          cz_q <= (opy >= 0) ? 26'(HalfTurn) : -26'(HalfTurn);
        end else begin
          cx_q <= opx;
          cy_q <= opy;
          cz_q <= '0;
        end
      end
      S_CORD: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + tab_s;
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - tab_s;
        end
      end
      S_CFIN: begin
        unique case (ax_q)
          2'd0:    hd_q <= zres[14:0];
          2'd1:    rl_q <= zres[14:0];
          default: pt_q <= zres[13:0];
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          m_user_q <= status_q;
          if (status_q == StatusValid) begin
            m_data_q <= {4'd0, gain_q, pt_q, rl_q, hd_q, mz_q, my_q, mx_q};
          end else begin
            m_data_q <= {4'd0, gain_q, 89'd0};
          end
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign cfg_ready_o     = 1'b1;

endmodule

/* rtl/mah_checker.sv */
`timescale 1ns / 1ps
module mah_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A result that waits must hold its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  // Only the three defined status codes leave the block.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("undefined status code");

  // Retry and not-ready items carry no measurement.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != 2'd0) |-> (m_axis_tdata_o[88:0] == 89'd0))
    else $error("measurement fields not cleared");

  // The gain step stays in range.
  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[91:89] <= 3'd6))
    else $error("gain step out of range");

  // An item is taken only while no earlier one is being worked on.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

endmodule

bind magnetometer_autorange_heading mah_checker u_mah_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
